### rtl/bounded_double_ended_queue_unit_defines.svh
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and quiet in reset.
`define BDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and quiet in reset.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 2;
   localparam int CAP_W         = 5;
   localparam int CAP_MAX       = 2**CAP_W - 1;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // Word index of the capacity register (byte address 0).
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_READ_FRONT = 3'd4,
      CMD_READ_REAR  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

### rtl/bdq_csr.sv
`default_nettype none

module bdq_csr
   import bdq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [CAP_W-1:0]      capacity
);

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[2] == REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (wr_en) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_CAPACITY) begin
         csr_prdata = {{(CSR_DATA_W-CAP_W){1'b0}}, cap_ff};
      end
   end

   assign capacity = cap_ff;

endmodule

`default_nettype wire

### rtl/bdq_ctrl.sv
`default_nettype none

module bdq_ctrl
   import bdq_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output ctrl_cmd_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               if (req_valid) begin
                  ctrl.load = 1'b1;
                  state_in  = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/bdq_dpath.sv
`default_nettype none

module bdq_dpath
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ctrl_cmd_type               ctrl,
   input  wire logic [CAP_W-1:0]           capacity,
   input  wire logic [CMD_W-1:0]           req_command,
   input  wire logic signed [DATA_W-1:0]   req_data_in,
   output logic signed [DATA_W-1:0]        rsp_data_out,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [CAP_W-1:0]                rsp_entry_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CAP_W-1:0] DEPTH_CLAMP = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

   logic signed [DATA_W-1:0] mem [DEPTH];

   cmd_type                  cmd_ff;
   logic signed [DATA_W-1:0] din_ff;
   logic signed [DATA_W-1:0] rd_ff;
   status_type               status_ff;
   status_type               status_in;
   logic                     take_ff;
   logic                     take_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CAP_W-1:0]         occ_ff, occ_in;

   logic [CAP_W-1:0] eff_cap;
   logic             is_full_now;
   logic             is_empty_now;
   logic [IDX_W-1:0] head_next, head_prev, tail_next, tail_prev;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;

   assign eff_cap      = (capacity > DEPTH_CLAMP) ? DEPTH_CLAMP : capacity;
   assign is_full_now  = occ_ff >= eff_cap;
   assign is_empty_now = occ_ff == '0;

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      status_in = STATUS_OK;
      take_in   = 1'b0;
      rd_addr   = head_ff;
      wr_addr   = tail_ff;
      wr_en     = 1'b0;
      case (cmd_ff)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (is_full_now) begin
               status_in = STATUS_FULL;
            end else if (cmd_ff == CMD_PUSH_FRONT) begin
               wr_addr = head_prev;
               wr_en   = 1'b1;
               head_in = head_prev;
               occ_in  = occ_ff + 1'b1;
            end else begin
               wr_addr = tail_ff;
               wr_en   = 1'b1;
               tail_in = tail_next;
               occ_in  = occ_ff + 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_READ_FRONT: begin
            if (is_empty_now) begin
               status_in = STATUS_EMPTY;
            end else begin
               take_in = 1'b1;
               rd_addr = head_ff;
               if (cmd_ff == CMD_POP_FRONT) begin
                  head_in = head_next;
                  occ_in  = occ_ff - 1'b1;
               end
            end
         end
         CMD_POP_REAR, CMD_READ_REAR: begin
            if (is_empty_now) begin
               status_in = STATUS_EMPTY;
            end else begin
               take_in = 1'b1;
               rd_addr = tail_prev;
               if (cmd_ff == CMD_POP_REAR) begin
                  tail_in = tail_prev;
                  occ_in  = occ_ff - 1'b1;
               end
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= cmd_type'(req_command);
         din_ff <= req_data_in;
      end
      if (ctrl.exec) begin
         rd_ff     <= mem[rd_addr];
         status_ff <= status_in;
         take_ff   <= take_in;
         if (wr_en) begin
            mem[wr_addr] <= din_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (ctrl.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   assign rsp_data_out    = take_ff ? rd_ff : '0;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = occ_ff;
   assign rsp_is_empty    = is_empty_now;
   assign rsp_is_full     = is_full_now;

endmodule

`default_nettype wire

### rtl/bounded_double_ended_queue_unit.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit words kept in a ring memory of
// DEPTH entries with head and tail pointers and an entry count. Each request
// carries one command (push front, push rear, pop front, pop rear, read front
// or read rear) and yields exactly one response with the word popped or read,
// a status (ok, push rejected because full, or empty), the count after the
// command and the empty and full flags. The request is captured at the edge
// that accepts it. The next cycle executes it: the ring memory is read or
// written and the pointers move. The response is valid from the edge after
// that. A new request is accepted in the same cycle the previous response is
// taken, so requests never overlap: each is executed and answered before the
// next one is captured. The capacity register (byte address 0) resets to 16,
// is clamped to DEPTH and should be written only while no request is in
// flight. Entries are never cleared; lowering capacity below the current
// count keeps the entries and only blocks further pushes.

module bounded_double_ended_queue_unit
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request channel.
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic signed [DATA_W-1:0] req_data_in,
   // Response channel.
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_data_out,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic [CAP_W-1:0]              rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,
   // Configuration port.
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   ctrl_cmd_type     ctrl;
   logic [CAP_W-1:0] capacity;

   // Capacity register.
   bdq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   // The controller sequences capture, execute and respond; it also owns both
   // handshakes so that the datapath only sees load and execute strobes.
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // The datapath holds the ring memory, the pointers and the response fields.
   // Response fields stay stable while the controller waits in its response
   // state, since the pointers and count only move on an execute strobe.
   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .capacity        (capacity),
      .req_command     (req_command),
      .req_data_in     (req_data_in),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

`default_nettype wire

### rtl/bdq_checker.sv
`default_nettype none

`include "bounded_double_ended_queue_unit_defines.svh"

module bdq_checker
   import bdq_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [DATA_W-1:0] rsp_data_out,
   input wire logic [STATUS_W-1:0]      rsp_status,
   input wire logic [CAP_W-1:0]         rsp_entry_count,
   input wire logic                     rsp_is_empty,
   input wire logic                     rsp_is_full
);

   // A rising response valid must follow an accepted request by way of the execute state.
   `BDQ_ASSERT_IMPL(a_rsp_follows_req, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "response without a request")

   // The empty flag and the count must agree.
   `BDQ_ASSERT_IMPL(a_empty_flag, rsp_valid, rsp_is_empty == (rsp_entry_count == '0), "empty flag disagrees with count")

   // A rejected push only happens on a full deque.
   `BDQ_ASSERT_IMPL(a_full_status, rsp_valid && (rsp_status == STATUS_FULL), rsp_is_full, "full status without full flag")

   // An empty status means nothing is held and no data comes back.
   `BDQ_ASSERT_IMPL(a_empty_status, rsp_valid && (rsp_status == STATUS_EMPTY), rsp_is_empty && (rsp_data_out == '0), "empty status with data or entries")

   // A stalled response holds.
   `BDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data_out) && $stable(rsp_entry_count), "stalled response changed")

endmodule

bind bounded_double_ended_queue_unit bdq_checker u_bdq_checker (.*);

`default_nettype wire

### bench/bounded_double_ended_queue_unit_checker.sv
`default_nettype none

// Watches both channels and the register port of the deque unit. It keeps its
// own copy of the ring, the pointers and the capacity, works out the response
// for every accepted request and compares each accepted response, field by
// field, with the oldest response still awaited.
module bounded_double_ended_queue_unit_checker
   import bdq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic signed [DATA_W-1:0] req_data_in,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic signed [DATA_W-1:0] rsp_data_out,
   input  wire logic [STATUS_W-1:0]      rsp_status,
   input  wire logic [CAP_W-1:0]         rsp_entry_count,
   input  wire logic                     rsp_is_empty,
   input  wire logic                     rsp_is_full,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]    csr_pwdata,
   input  wire logic                     csr_pready,
   output int                            mismatch_count,
   output int                            awaited_count,
   output int                            full_rejects,
   output int                            empty_replies
);

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [CAP_W-1:0]    count;
      logic                empty;
      logic                full;
   } deque_reply_type;

   logic [DATA_W-1:0] model_ring [DEPTH];
   logic [IDX_W-1:0]  front_slot;
   logic [IDX_W-1:0]  back_slot;
   logic [CAP_W-1:0]  held;
   logic [CAP_W-1:0]  capacity_reg;
   deque_reply_type   awaited_responses [$];

   function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   // Applies one command to the local copy of the deque and returns the
   // response it must produce.
   function automatic deque_reply_type run_deque_command(input logic [CMD_W-1:0] cmd,
                                                         input logic [DATA_W-1:0] din);
      deque_reply_type  r;
      logic [CAP_W-1:0] limit;
      logic [IDX_W-1:0] slot;
      r = '0;
      limit = (capacity_reg > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity_reg;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (held >= limit) begin
               r.status = STATUS_FULL;
            end else if (cmd == CMD_PUSH_FRONT) begin
               front_slot = slot_before(front_slot);
               model_ring[front_slot] = din;
               held = held + 1'b1;
            end else begin
               model_ring[back_slot] = din;
               back_slot = slot_after(back_slot);
               held = held + 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR, CMD_READ_FRONT, CMD_READ_REAR: begin
            if (held == '0) begin
               r.status = STATUS_EMPTY;
            end else begin
               slot = (cmd == CMD_POP_FRONT || cmd == CMD_READ_FRONT) ?
                      front_slot : slot_before(back_slot);
               r.data = model_ring[slot];
               if (cmd == CMD_POP_FRONT) begin
                  front_slot = slot_after(front_slot);
                  held = held - 1'b1;
               end else if (cmd == CMD_POP_REAR) begin
                  back_slot = slot;
                  held = held - 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.count = held;
      r.empty = (held == '0);
      r.full  = (held >= limit);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want_v,
                                input logic [DATA_W-1:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
   endtask

   always @(posedge clock) begin : watch_channels
      deque_reply_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++)
            model_ring[i] = '0;
         front_slot   = '0;
         back_slot    = '0;
         held         = '0;
         capacity_reg = CAP_RESET;
         awaited_responses.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CAPACITY_ADDR)
            capacity_reg = csr_pwdata[CAP_W-1:0];
         // The request is queued first, so a response at the same edge still
         // meets the oldest awaited one.
         if (req_valid && !req_stall)
            awaited_responses.push_back(run_deque_command(req_command, req_data_in));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               note_mismatch("response with nothing awaited", '0, rsp_data_out);
            end else begin
               want = awaited_responses.pop_front();
               if (want.status == STATUS_FULL)
                  full_rejects++;
               if (want.status == STATUS_EMPTY)
                  empty_replies++;
               if (rsp_data_out !== want.data)
                  note_mismatch("data_out", want.data, rsp_data_out);
               if (rsp_status !== want.status)
                  note_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_status));
               if (rsp_entry_count !== want.count)
                  note_mismatch("entry_count", DATA_W'(want.count),
                                DATA_W'(rsp_entry_count));
               if (rsp_is_empty !== want.empty)
                  note_mismatch("is_empty", DATA_W'(want.empty), DATA_W'(rsp_is_empty));
               if (rsp_is_full !== want.full)
                  note_mismatch("is_full", DATA_W'(want.full), DATA_W'(rsp_is_full));
            end
         end
      end
      awaited_count <= awaited_responses.size();
   end

endmodule

`default_nettype wire

### bench/bounded_double_ended_queue_unit_test.sv
`default_nettype none

// Top of the deque unit bench. It makes the clock, the single reset, the
// request traffic, the response stalls and the register writes, and gives the
// verdict. All prediction and comparison lives in the checker instance.
module bounded_double_ended_queue_unit_test;
   import bdq_pkg::*;

   // Command codes the block does not define; they must leave the deque alone.
   localparam logic [CMD_W-1:0] CMD_UNDEF_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNDEF_B = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

   // Which way a phase of random traffic pushes the fill level.
   typedef enum int {
      LEAN_PUSH = 0,
      LEAN_POP  = 1,
      LEAN_EVEN = 2
   } traffic_lean_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command;
   logic signed [DATA_W-1:0] req_data_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [STATUS_W-1:0]      rsp_status;
   logic [CAP_W-1:0]         rsp_entry_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // Chance in percent that a request is preceded by a gap, and that the
   // response side starts a stall burst. Each phase sets its own values.
   int gap_pct   = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int cap_writes = 0;

   int mismatch_count;
   int awaited_count;
   int full_rejects;
   int empty_replies;

   bounded_double_ended_queue_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   bounded_double_ended_queue_unit_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .awaited_count   (awaited_count),
      .full_rejects    (full_rejects),
      .empty_replies   (empty_replies)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Safety net: the slowest legal run is far below this.
   initial begin
      #4000000;
      $display("bounded_double_ended_queue_unit_test NOT OK");
      $finish;
   end

   // Response-side back pressure. Stall bursts start at random; when stall_pct is
   // zero the channel runs freely.
   initial begin : rsp_stall_gen
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(1, 18) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Presents one request and returns at the edge where it is accepted. An idle
   // gap may come first. The payload only changes after acceptance, and valid is
   // assigned once per time step.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] word);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_data_in <= word;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Holds off new requests until every awaited response has come back. The
   // awaited count is updated with a nonblocking assignment, so the value seen
   // here always reflects the previous edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   // Writes the capacity register while the block is idle: a setup phase, then
   // an access phase that ends at the edge where pready is high.
   task automatic write_capacity(input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cap_writes++;
   endtask

   // Picks a command with a mix that drives the fill level up, down, or
   // around the middle. A few undefined codes are mixed in as noise.
   function automatic logic [CMD_W-1:0] pick_command(input traffic_lean_type lean);
      int r;
      int push_pct;
      int pop_pct;
      r = $urandom_range(0, 99);
      case (lean)
         LEAN_PUSH: begin
            push_pct = 60;
            pop_pct  = 22;
         end
         LEAN_POP: begin
            push_pct = 20;
            pop_pct  = 60;
         end
         default: begin
            push_pct = 40;
            pop_pct  = 40;
         end
      endcase
      if (r < push_pct)
         return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      else if (r < push_pct + pop_pct)
         return $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
      else if (r < 97)
         return $urandom_range(0, 1) ? CMD_READ_REAR : CMD_READ_FRONT;
      else
         return $urandom_range(0, 1) ? CMD_UNDEF_B : CMD_UNDEF_A;
   endfunction

   // Mostly random words, with the signed extremes and the all-zero and
   // all-one patterns showing up now and then.
   function automatic logic [DATA_W-1:0] pick_word();
      if ($urandom_range(0, 99) < 80)
         return $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   initial begin : stimulus
      int               spin;
      traffic_lean_type lean;
      logic [CAP_W-1:0] cap_value;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_PUSH_FRONT;
      req_data_in = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset capacity of sixteen. Every read and pop on
      // the empty deque must report empty, and the undefined codes must do
      // nothing at all.
      send_request(CMD_READ_FRONT, 32'hFFFF_FFFF);
      send_request(CMD_READ_REAR,  32'h0000_0000);
      send_request(CMD_POP_FRONT,  32'hFFFF_FFFF);
      send_request(CMD_POP_REAR,   32'h0000_0000);
      send_request(CMD_UNDEF_A,    32'hFFFF_FFFF);
      send_request(CMD_UNDEF_B,    32'hFFFF_FFFF);
      // Signed extremes pushed at both ends, then peeked and drained from
      // alternating ends so the order of both pointers is exercised.
      send_request(CMD_PUSH_FRONT, 32'h8000_0000);
      send_request(CMD_PUSH_REAR,  32'h7FFF_FFFF);
      send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      send_request(CMD_PUSH_REAR,  32'h0000_0000);
      send_request(CMD_READ_FRONT, 32'h0000_0000);
      send_request(CMD_READ_REAR,  32'h0000_0000);
      send_request(CMD_UNDEF_A,    32'h1234_5678);
      send_request(CMD_POP_REAR,   32'h0000_0000);
      send_request(CMD_POP_FRONT,  32'h0000_0000);
      send_request(CMD_POP_REAR,   32'h0000_0000);
      send_request(CMD_POP_FRONT,  32'h0000_0000);
      send_request(CMD_POP_FRONT,  32'h0000_0000);

      // A capacity of zero rejects every push and reports empty and full at
      // once.
      write_capacity(32'd0);
      send_request(CMD_PUSH_FRONT, 32'h5555_5555);
      send_request(CMD_PUSH_REAR,  32'hAAAA_AAAA);
      send_request(CMD_READ_FRONT, 32'h0000_0000);

      // A capacity of one: a single entry fills the deque.
      write_capacity(32'd1);
      send_request(CMD_PUSH_REAR,  32'h1234_5678);
      send_request(CMD_PUSH_FRONT, 32'h8765_4321);
      send_request(CMD_POP_FRONT,  32'h0000_0000);

      // Random phases. The first few are fixed so that the deque fills at the
      // full depth, has its capacity lowered below the count it holds, sees
      // capacities above the depth that must clamp, and sees zero and one
      // again under load. The middle ones pick capacities at random, with garbage in
      // the unused upper bits of the write data. Idling changes per phase so
      // some stretches run without any gaps or stalls.
      for (int phase = 0; phase < 18; phase++) begin
         case (phase)
            0: begin
               cap_value = 5'd16;
               lean      = LEAN_PUSH;
            end
            1: begin
               cap_value = 5'd5;
               lean      = LEAN_POP;
            end
            2: begin
               cap_value = 5'd0;
               lean      = LEAN_EVEN;
            end
            3: begin
               cap_value = 5'd31;
               lean      = LEAN_PUSH;
            end
            4: begin
               cap_value = 5'd17;
               lean      = LEAN_POP;
            end
            5: begin
               cap_value = 5'd1;
               lean      = LEAN_EVEN;
            end
            17: begin
               cap_value = 5'd16;
               lean      = LEAN_EVEN;
            end
            default: begin
               cap_value = CAP_W'($urandom_range(0, 31));
               lean      = traffic_lean_type'(phase % 3);
            end
         endcase
         if (phase >= 6 && phase < 17)
            write_capacity({27'($urandom_range(0, 2**27 - 1)), cap_value});
         else
            write_capacity({27'd0, cap_value});

         // The final phase runs with no idling on either side.
         gap_pct   = (phase == 17 || phase % 4 == 3) ? 0 : 20;
         stall_pct = (phase == 17 || phase % 4 == 1) ? 0 : 15;
         for (int n = 0; n < 57; n++)
            send_request(pick_command(lean), pick_word());
      end

      // Let everything drain, then give any stray response time to show up.
      req_valid <= 1'b0;
      stall_pct = 0;
      spin = 0;
      do begin
         @(posedge clock);
         spin++;
      end while (awaited_count != 0 && spin < 5000);
      repeat (12) @(posedge clock);

      if (awaited_count != 0)
         $display("%0d responses were still outstanding at the end", awaited_count);
      $display("Sent %0d requests under %0d capacity settings, including zero, one, full",
               sent_count, cap_writes);
      $display("depth and clamped values; %0d full rejections and %0d empty replies seen.",
               full_rejects, empty_replies);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("bounded_double_ended_queue_unit_test OK");
      end else begin
         $display("bounded_double_ended_queue_unit_test NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
